// ----- hdl/lfk_pkg.sv -----
// shared constants, register codes and latency helpers for the leg kinematics block
package lfk_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int POS_WIDTH_DEF   = 16;
  localparam int LINK_W          = 14;
  localparam int TRIG_W          = 32;
  localparam int CFG_AW          = 4;
  localparam int CFG_DW          = 32;

  localparam logic [LINK_W-1:0] HIP_LINK_RST   = 14'd1393;
  localparam logic [LINK_W-1:0] UPPER_LINK_RST = 14'd3277;
  localparam logic [LINK_W-1:0] LOWER_LINK_RST = 14'd3277;

  localparam logic [1:0] REG_HIP_LINK   = 2'd0;
  localparam logic [1:0] REG_UPPER_LINK = 2'd1;
  localparam logic [1:0] REG_LOWER_LINK = 2'd2;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

  localparam int SIN_TERMS = 5;
  localparam int COS_TERMS = 6;
  localparam int SIN_DIV [SIN_TERMS] = '{110, 72, 42, 20, 6};
  localparam int COS_DIV [COS_TERMS] = '{132, 90, 56, 30, 12, 2};

  localparam int SQRT_STEPS = 15;
  localparam int ROOT_W     = 31;
  localparam int LSQ_W      = 30;
  localparam int LEN_W      = 16;

  // conditional subtract steps needed to bring |angle| below two pi
  function automatic int red_steps(input int aw);
    return (aw > 16) ? aw - 15 : 1;
  endfunction

  // abs, reduction, two folds, square, horner cells, sign
  function automatic int trig_latency(input int aw);
    return red_steps(aw) + 2 * COS_TERMS + 5;
  endfunction

endpackage

// ----- hdl/lfk_delay.sv -----
// enabled shift line used to line up operands across the pipeline
module lfk_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q = line_r[DEPTH-1];

endmodule

// ----- hdl/lfk_horner_cell.sv -----
// one horner step t' = 1 - (x2/DIV)*t, two pipeline stages
module lfk_horner_cell #(
  parameter int DIV = 2
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        x2_i,
  input  logic signed [31:0] t_i,
  output logic [31:0]        x2_o,
  output logic signed [31:0] t_o
);
  import lfk_pkg::*;

  localparam int SH = 32 + $clog2(DIV);
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

  logic [64:0]        qprod;
  logic [31:0]        q_nxt;
  logic [31:0]        q_r;
  logic [31:0]        x2a_r;
  logic signed [31:0] ta_r;
  logic [62:0]        tprod;
  logic signed [31:0] t_nxt;
  logic signed [31:0] t_r;
  logic [31:0]        x2_r;

  // exact floor division by reciprocal, valid for any 32-bit dividend
  assign qprod = 65'(x2_i) * 65'(RECIP[32:0]);
  assign q_nxt = 32'(qprod >> SH);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= q_nxt;
      x2a_r <= x2_i;
      ta_r  <= t_i;
    end
  end

  assign tprod = 63'(q_r) * 63'(ta_r[30:0]);
  assign t_nxt = $signed(Q30_ONE[31:0] - tprod[61:30]);

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= t_nxt;
      x2_r <= x2a_r;
    end
  end

  assign x2_o = x2_r;
  assign t_o  = t_r;

endmodule

// ----- hdl/lfk_sqrt_cell.sv -----
// one digit of the restoring integer square root
module lfk_sqrt_cell #(
  parameter int BIT_IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [30:0]       rem_i,
  input  logic [30:0]       root_i,
  output logic [30:0]       rem_o,
  output logic [30:0]       root_o
);
  import lfk_pkg::*;

  localparam logic [30:0] BIT = 31'(1) << (2 * BIT_IDX);

  logic [30:0] trial;
  logic        fits;
  logic [30:0] rem_nxt;
  logic [30:0] root_nxt;
  logic [30:0] rem_r;
  logic [30:0] root_r;

  assign trial    = root_i + BIT;
  assign fits     = rem_i >= trial;
  assign rem_nxt  = fits ? rem_i - trial : rem_i;
  assign root_nxt = fits ? (root_i >> 1) + BIT : root_i >> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// ----- hdl/lfk_sin_cos.sv -----
// pipelined sine and cosine of a q30 angle: reduction, fold, horner cell rows
module lfk_sin_cos #(
  parameter int ANGLE_WIDTH = lfk_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ANGLE_WIDTH+17:0] angle_i,
  output logic signed [31:0]            sin_o,
  output logic signed [31:0]            cos_o
);
  import lfk_pkg::*;

  localparam int AQW  = ANGLE_WIDTH + 18;
  localparam int MAGW = ANGLE_WIDTH + 17;
  localparam int NRED = red_steps(ANGLE_WIDTH);

  logic [AQW-1:0]  abs_full;
  logic [MAGW-1:0] red_m_r   [NRED+1];
  logic            red_neg_r [NRED+1];

  assign abs_full = angle_i[AQW-1] ? AQW'(-angle_i) : AQW'(angle_i);

  always_ff @(posedge clk) begin
    if (en) begin
      red_m_r[0]   <= abs_full[MAGW-1:0];
      red_neg_r[0] <= angle_i[AQW-1];
    end
  end

  // magnitude modulo two pi, one scaled subtract per stage
  for (genvar i = 0; i < NRED; i++) begin : g_red
    localparam int K = NRED - 1 - i;
    localparam logic [63:0] TPK = Q30_TWO_PI << K;
    logic [63:0] mz;
    assign mz = 64'(red_m_r[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        red_m_r[i+1]   <= (mz >= TPK) ? MAGW'(mz - TPK) : red_m_r[i];
        red_neg_r[i+1] <= red_neg_r[i];
      end
    end
  end

  logic [63:0] m64;
  logic [33:0] m0;
  logic        over_pi;
  logic [33:0] m0_flip;
  logic [32:0] f1_m_r;
  logic        f1_neg_r;

  assign m64     = 64'(red_m_r[NRED]);
  assign m0      = m64[33:0];
  assign over_pi = 64'(m0) > Q30_PI;
  assign m0_flip = Q30_TWO_PI[33:0] - m0;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_m_r   <= over_pi ? m0_flip[32:0] : m0[32:0];
      f1_neg_r <= red_neg_r[NRED] ^ over_pi;
    end
  end

  logic        over_half;
  logic [32:0] f1_flip;
  logic [30:0] x_r;
  logic        ns_r;
  logic        nc_r;

  assign over_half = 64'(f1_m_r) > Q30_HALF_PI;
  assign f1_flip   = Q30_PI[32:0] - f1_m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= over_half ? f1_flip[30:0] : f1_m_r[30:0];
      ns_r <= f1_neg_r;
      nc_r <= over_half;
    end
  end

  logic [61:0] xsq;
  logic [31:0] x2_r;
  logic [30:0] xq_r;
  logic [1:0]  flags_r;

  assign xsq = 62'(x_r) * 62'(x_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r    <= xsq[61:30];
      xq_r    <= x_r;
      flags_r <= {nc_r, ns_r};
    end
  end

  // sine row
  logic [31:0]        sx2 [SIN_TERMS];
  logic signed [31:0] st  [SIN_TERMS+1];

  assign sx2[0] = x2_r;
  assign st[0]  = $signed(Q30_ONE[31:0]);

  for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
    if (i == SIN_TERMS - 1) begin : g_last
      lfk_horner_cell #(.DIV(SIN_DIV[i])) u_cell (
        .clk(clk), .en(en), .x2_i(sx2[i]), .t_i(st[i]), .x2_o(), .t_o(st[i+1])
      );
    end else begin : g_mid
      lfk_horner_cell #(.DIV(SIN_DIV[i])) u_cell (
        .clk(clk), .en(en), .x2_i(sx2[i]), .t_i(st[i]), .x2_o(sx2[i+1]), .t_o(st[i+1])
      );
    end
  end

  // cosine row
  logic [31:0]        cx2 [COS_TERMS];
  logic signed [31:0] ct  [COS_TERMS+1];

  assign cx2[0] = x2_r;
  assign ct[0]  = $signed(Q30_ONE[31:0]);

  for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
    if (i == COS_TERMS - 1) begin : g_last
      lfk_horner_cell #(.DIV(COS_DIV[i])) u_cell (
        .clk(clk), .en(en), .x2_i(cx2[i]), .t_i(ct[i]), .x2_o(), .t_o(ct[i+1])
      );
    end else begin : g_mid
      lfk_horner_cell #(.DIV(COS_DIV[i])) u_cell (
        .clk(clk), .en(en), .x2_i(cx2[i]), .t_i(ct[i]), .x2_o(cx2[i+1]), .t_o(ct[i+1])
      );
    end
  end

  logic [30:0] x_d;
  logic [1:0]  flags_d;

  lfk_delay #(.WIDTH(31), .DEPTH(2 * SIN_TERMS)) u_x_dly (
    .clk(clk), .en(en), .d(xq_r), .q(x_d)
  );

  lfk_delay #(.WIDTH(2), .DEPTH(2 * COS_TERMS)) u_flag_dly (
    .clk(clk), .en(en), .d(flags_r), .q(flags_d)
  );

  logic [61:0]        sprod;
  logic signed [31:0] s_r;
  logic signed [31:0] sd_r;
  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;

  assign sprod = 62'(x_d) * 62'(st[SIN_TERMS][30:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= $signed({1'b0, sprod[60:30]});
      sd_r  <= s_r;
      sin_r <= flags_d[0] ? -sd_r : sd_r;
      cos_r <= flags_d[1] ? -ct[COS_TERMS] : ct[COS_TERMS];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ----- hdl/leg_forward_kinematics_top.sv -----
// top level of the three-joint leg forward kinematics pipeline
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata: abduction, thigh, knee; tuser: side
//  out_    | out | out_tvalid / out_tready| tdata: foot_x, foot_y, foot_z
//  cfg_    | in  | apb psel/penable       | hip, upper, lower link lengths at 0, 4, 8
//
// one beat accepted every cycle while the second output buffer entry is empty; the
// result path runs through the knee cosine, the square root cell row and the
// abduction rotation in sequence
// synchronous active-low reset loads the reset link lengths and clears the valid
// line and output buffer
// the whole pipeline moves on one enable; a two-entry output buffer lets it keep
// accepting while a result waits, and it holds only once both entries are full
module leg_forward_kinematics_top #(
  parameter int ANGLE_WIDTH = lfk_pkg::ANGLE_WIDTH_DEF,
  parameter int POS_WIDTH   = lfk_pkg::POS_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // abduction_angle, thigh_angle, knee_angle from bit 0 up, zero padded
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]    in_tdata,
  // side_negative
  input  logic                                  in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // foot_x, foot_y, foot_z from bit 0 up, zero padded
  output logic [((3*POS_WIDTH+7)/8)*8-1:0]      out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [lfk_pkg::CFG_AW-1:0]            cfg_paddr,
  input  logic [lfk_pkg::CFG_DW-1:0]            cfg_pwdata,
  output logic [lfk_pkg::CFG_DW-1:0]            cfg_prdata,
  output logic                                  cfg_pready
);
  import lfk_pkg::*;

  localparam int AW       = ANGLE_WIDTH;
  localparam int PW       = POS_WIDTH;
  localparam int AQW      = AW + 18;
  localparam int OUT_DW   = ((3 * PW + 7) / 8) * 8;
  localparam int TRIG_LAT = trig_latency(AW);
  localparam int LAT      = 1 + TRIG_LAT + 23;

  localparam logic signed [63:0] RND_H  = 64'sd536870912;
  localparam logic signed [63:0] POS_HI = (64'sd1 <<< (PW - 1)) - 64'sd1;
  localparam logic signed [63:0] POS_LO = -POS_HI - 64'sd1;

  // round q30 to integer, halves away from zero
  function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] v);
    return (v + (v[63] ? RND_H - 64'sd1 : RND_H)) >>> 30;
  endfunction

  function automatic logic [PW-1:0] sat_pos(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > POS_HI) c = POS_HI;
    if (v < POS_LO) c = POS_LO;
    return c[PW-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [LINK_W-1:0] hip_r, upper_r, lower_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hip_r   <= HIP_LINK_RST;
      upper_r <= UPPER_LINK_RST;
      lower_r <= LOWER_LINK_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HIP_LINK:   hip_r   <= cfg_pwdata[LINK_W-1:0];
        REG_UPPER_LINK: upper_r <= cfg_pwdata[LINK_W-1:0];
        REG_LOWER_LINK: lower_r <= cfg_pwdata[LINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HIP_LINK:   cfg_prdata = CFG_DW'(hip_r);
      REG_UPPER_LINK: cfg_prdata = CFG_DW'(upper_r);
      REG_LOWER_LINK: cfg_prdata = CFG_DW'(lower_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // link products follow the registers, settled long before an item needs them
  logic [28:0] ul2_r;
  logic [29:0] uull_r;

  always_ff @(posedge clk) begin
    ul2_r  <= 29'({upper_r, 1'b0} * 29'(lower_r));
    uull_r <= 30'(upper_r) * 30'(upper_r) + 30'(lower_r) * 30'(lower_r);
  end

  // ---------------- flow control ----------------
  logic          adv;
  logic [LAT-1:0] v_r;
  logic          head_v_r, skid_v_r;
  logic [3*PW-1:0] head_r, skid_r;
  logic          push, pop;

  assign adv       = ~skid_v_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------- input capture ----------------
  logic signed [AW-1:0] ab_r, th_r, kn_r;
  logic                 side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ab_r   <= $signed(in_tdata[AW-1:0]);
      th_r   <= $signed(in_tdata[2*AW-1:AW]);
      kn_r   <= $signed(in_tdata[3*AW-1:2*AW]);
      side_r <= in_tuser;
    end
  end

  // angles in q30: q2.13 times 2^17, swing angle adds half the knee
  logic signed [AQW-1:0] ab_q, e_q, kn_q;

  assign ab_q = AQW'(ab_r) <<< 17;
  assign kn_q = AQW'(kn_r) <<< 17;
  assign e_q  = (AQW'(th_r) <<< 17) + (AQW'(kn_r) <<< 16);

  logic signed [31:0] s_k, c_k, s_e, c_e, s_a, c_a;

  lfk_sin_cos #(.ANGLE_WIDTH(AW)) u_trig_knee (
    .clk(clk), .en(adv), .angle_i(kn_q), .sin_o(s_k), .cos_o(c_k)
  );

  lfk_sin_cos #(.ANGLE_WIDTH(AW)) u_trig_swing (
    .clk(clk), .en(adv), .angle_i(e_q), .sin_o(s_e), .cos_o(c_e)
  );

  lfk_sin_cos #(.ANGLE_WIDTH(AW)) u_trig_abd (
    .clk(clk), .en(adv), .angle_i(ab_q), .sin_o(s_a), .cos_o(c_a)
  );

  // knee sine is not needed; the fold keeps both so the units stay identical
  logic unused_sk;
  assign unused_sk = ^s_k;

  // ---------------- leg length ----------------
  logic signed [61:0] pk_r;
  logic signed [31:0] rk_r;
  logic signed [32:0] lsq_sum;
  logic [LSQ_W-1:0]   lsq_r;

  assign lsq_sum = $signed({3'b000, uull_r}) + 33'(rk_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      pk_r  <= $signed({1'b0, ul2_r}) * c_k;
      rk_r  <= 32'(rnd_q30(64'(pk_r)));
      lsq_r <= lsq_sum[32] ? '0 : lsq_sum[LSQ_W-1:0];
    end
  end

  // square root, one result bit per cell
  logic [ROOT_W-1:0] rem_w  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_w [SQRT_STEPS+1];

  assign rem_w[0]  = ROOT_W'(lsq_r);
  assign root_w[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    if (i == SQRT_STEPS - 1) begin : g_last
      lfk_sqrt_cell #(.BIT_IDX(SQRT_STEPS - 1 - i)) u_cell (
        .clk(clk), .en(adv), .rem_i(rem_w[i]), .root_i(root_w[i]),
        .rem_o(), .root_o(root_w[i+1])
      );
    end else begin : g_mid
      lfk_sqrt_cell #(.BIT_IDX(SQRT_STEPS - 1 - i)) u_cell (
        .clk(clk), .en(adv), .rem_i(rem_w[i]), .root_i(root_w[i]),
        .rem_o(rem_w[i+1]), .root_o(root_w[i+1])
      );
    end
  end

  logic [LEN_W-1:0] len;
  assign len = root_w[SQRT_STEPS][LEN_W-1:0];

  // ---------------- operand alignment ----------------
  logic signed [31:0] nse_d, nce_d, s_a_d, c_a_d;
  logic               side_d;

  // swing terms are negated on entry so the offsets need no later negation
  lfk_delay #(.WIDTH(64), .DEPTH(SQRT_STEPS + 3)) u_swing_dly (
    .clk(clk), .en(adv), .d({-s_e, -c_e}), .q({nse_d, nce_d})
  );

  lfk_delay #(.WIDTH(64), .DEPTH(SQRT_STEPS + 5)) u_abd_dly (
    .clk(clk), .en(adv), .d({s_a, c_a}), .q({s_a_d, c_a_d})
  );

  lfk_delay #(.WIDTH(1), .DEPTH(TRIG_LAT + SQRT_STEPS + 5)) u_side_dly (
    .clk(clk), .en(adv), .d(side_r), .q(side_d)
  );

  // ---------------- foot offsets ----------------
  logic signed [48:0] px_r, pz_r;
  logic signed [18:0] offx_r, offz_r, offx1_r, offx2_r;
  logic signed [14:0] h_s;
  logic signed [46:0] ya_r, za_r;
  logic signed [50:0] yb_r, zb_r;
  logic signed [51:0] ys_r, zs_r;
  logic [PW-1:0]      fx_r, fy_r, fz_r;

  assign h_s = side_d ? -$signed({1'b0, hip_r}) : $signed({1'b0, hip_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r    <= $signed({1'b0, len}) * nse_d;
      pz_r    <= $signed({1'b0, len}) * nce_d;
      offx_r  <= 19'(rnd_q30(64'(px_r)));
      offz_r  <= 19'(rnd_q30(64'(pz_r)));
      // rotate the y/z offsets by the abduction angle
      ya_r    <= c_a_d * h_s;
      yb_r    <= s_a_d * offz_r;
      za_r    <= s_a_d * h_s;
      zb_r    <= c_a_d * offz_r;
      offx1_r <= offx_r;
      ys_r    <= 52'(ya_r) - 52'(yb_r);
      zs_r    <= 52'(za_r) + 52'(zb_r);
      offx2_r <= offx1_r;
      fx_r    <= sat_pos(64'(offx2_r));
      fy_r    <= sat_pos(rnd_q30(64'(ys_r)));
      fz_r    <= sat_pos(rnd_q30(64'(zs_r)));
    end
  end

  // ---------------- output buffer ----------------
  assign push = adv & v_r[LAT-1];
  assign pop  = head_v_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        head_r   <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (head_v_r) begin
      if (pop && push) begin
        head_r <= {fz_r, fy_r, fx_r};
      end else if (pop) begin
        head_v_r <= 1'b0;
      end else if (push) begin
        skid_r   <= {fz_r, fy_r, fx_r};
        skid_v_r <= 1'b1;
      end
    end else if (push) begin
      head_r   <= {fz_r, fy_r, fx_r};
      head_v_r <= 1'b1;
    end
  end

  assign out_tvalid = head_v_r;
  assign out_tdata  = OUT_DW'(head_r);

endmodule
